// ===== hw/rtl/owpc_pkg.sv =====
// ----------------------------------------------------------------------------
// owpc_pkg
// Types, register indexes and helpers for the overlap window pair counter.
// ----------------------------------------------------------------------------
package owpc_pkg;

  localparam int OWPC_WINDOW_DEPTH = 64;
  localparam int CNT_W             = 48;
  localparam int CFG_IDX_W         = 8;
  localparam int CFG_DATA_W        = 16;

  localparam logic [CFG_IDX_W-1:0] REG_RD_LEN   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SEED_LEN = CFG_IDX_W'(1);

  localparam logic [15:0] RD_LEN_RST   = 16'd100;
  localparam logic [15:0] SEED_LEN_RST = 16'd31;

  typedef struct packed {
    logic [31:0] ref_name;
    logic [31:0] map_position;
    logic [15:0] part_id;
    logic        start_of_set;
  } owpc_in_t;

  typedef struct packed {
    logic [CNT_W-1:0] total_pairs;
    logic [CNT_W-1:0] intra_pairs;
    logic [CNT_W-1:0] inter_pairs;
    logic             window_overflow;
  } owpc_out_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } owpc_cfg_t;

  // one window entry as it moves down the cell row
  typedef struct packed {
    logic [31:0] ref_name;
    logic [31:0] pos;
    logic [15:0] part;
  } owpc_entry_t;

  // compare result of one cell against the incoming record
  typedef struct packed {
    logic vld;
    logic keep;
    logic same_part;
  } owpc_cell_stat_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/owpc_in_if.sv =====
// ----------------------------------------------------------------------------
// owpc_in_if
// Record request channel: valid, ready and one aligned record.
// ----------------------------------------------------------------------------
interface owpc_in_if import owpc_pkg::*; ();
  logic     valid;
  logic     ready;
  owpc_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/owpc_out_if.sv =====
// ----------------------------------------------------------------------------
// owpc_out_if
// Result request channel: valid, ready and the running pair counts.
// ----------------------------------------------------------------------------
interface owpc_out_if import owpc_pkg::*; ();
  logic      valid;
  logic      ready;
  owpc_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/owpc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// owpc_cfg_if
// Register write channel: valid, ready, register index and write data.
// ----------------------------------------------------------------------------
interface owpc_cfg_if import owpc_pkg::*; ();
  logic      valid;
  logic      ready;
  owpc_cfg_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/owpc_cell.sv =====
// ----------------------------------------------------------------------------
// owpc_cell
// One window entry: compares itself with the incoming record and takes over
// its upstream neighbour's entry on every accepted request.
// ----------------------------------------------------------------------------
module owpc_cell import owpc_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            shift_en,
  input  logic            start,
  input  logic [31:0]     rec_ref,
  input  logic [15:0]     rec_part,
  input  logic [32:0]     need,
  input  logic [15:0]     rd_len,
  input  owpc_entry_t     prev_ent,
  input  logic            prev_keep,
  output owpc_entry_t     ent,
  output owpc_cell_stat_t stat
);

  owpc_entry_t ent_r;
  logic        vld_r;
  logic [32:0] reach;

  assign reach          = {1'b0, ent_r.pos} + {17'b0, rd_len};
  assign stat.vld       = vld_r;
  assign stat.keep      = vld_r && !start && (ent_r.ref_name == rec_ref) && (reach >= need);
  assign stat.same_part = (ent_r.part == rec_part);
  assign ent            = ent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (shift_en) begin
      vld_r <= prev_keep;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      ent_r <= prev_ent;
    end
  end

endmodule

// ===== hw/rtl/owpc_popcnt.sv =====
// ----------------------------------------------------------------------------
// owpc_popcnt
// Four-stage registered population count over the match vector of the row.
// ----------------------------------------------------------------------------
module owpc_popcnt #(
  parameter int N = 64
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [N-1:0]           bits,
  output logic [$clog2(N+1)-1:0] cnt
);

  localparam int CW = $clog2(N + 1);
  localparam int G1 = (N + 7) / 8;
  localparam int G2 = (G1 + 7) / 8;
  localparam int G3 = (G2 + 7) / 8;

  logic [G1*8-1:0] pad;
  logic [CW-1:0]   l1_sum [G1];
  logic [CW-1:0]   l1_r   [G1];
  logic [CW-1:0]   l1_pad [G2*8];
  logic [CW-1:0]   l2_sum [G2];
  logic [CW-1:0]   l2_r   [G2];
  logic [CW-1:0]   l2_pad [G3*8];
  logic [CW-1:0]   l3_sum [G3];
  logic [CW-1:0]   l3_r   [G3];
  logic [CW-1:0]   fin_sum;
  logic [CW-1:0]   cnt_r;

  assign pad = (G1*8)'(bits);

  genvar g;
  generate
    for (g = 0; g < G2*8; g++) begin : g_l1pad
      if (g < G1) begin : g_used
        assign l1_pad[g] = l1_r[g];
      end else begin : g_zero
        assign l1_pad[g] = '0;
      end
    end
    for (g = 0; g < G3*8; g++) begin : g_l2pad
      if (g < G2) begin : g_used
        assign l2_pad[g] = l2_r[g];
      end else begin : g_zero
        assign l2_pad[g] = '0;
      end
    end
  endgenerate

  always_comb begin
    for (int i = 0; i < G1; i++) begin
      l1_sum[i] = '0;
      for (int j = 0; j < 8; j++) begin
        l1_sum[i] = l1_sum[i] + CW'(pad[i*8+j]);
      end
    end
    for (int i = 0; i < G2; i++) begin
      l2_sum[i] = '0;
      for (int j = 0; j < 8; j++) begin
        l2_sum[i] = l2_sum[i] + l1_pad[i*8+j];
      end
    end
    for (int i = 0; i < G3; i++) begin
      l3_sum[i] = '0;
      for (int j = 0; j < 8; j++) begin
        l3_sum[i] = l3_sum[i] + l2_pad[i*8+j];
      end
    end
    fin_sum = '0;
    for (int i = 0; i < G3; i++) begin
      fin_sum = fin_sum + l3_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l1_r  <= l1_sum;
      l2_r  <= l2_sum;
      l3_r  <= l3_sum;
      cnt_r <= fin_sum;
    end
  end

  assign cnt = cnt_r;

endmodule

// ===== hw/rtl/overlap_window_pair_counter_unit.sv =====
// After its request is accepted, a result passes the match register, the
// 4-stage popcount tree and the result register before it is offered.
// Throughput: one request per cycle while results are taken; a stalled result
// holds the cell row and the popcount pipeline. Reset: synchronous, active
// low; window empty, counts and overflow cleared, read length 100, minimum
// overlap 31.
// ----------------------------------------------------------------------------
// overlap_window_pair_counter_unit
// Sliding window of aligned records in a row of cells; counts overlapping
// pairs split into same-partition and cross-partition totals.
// ----------------------------------------------------------------------------
module overlap_window_pair_counter_unit import owpc_pkg::*; #(
  parameter int WINDOW_DEPTH = OWPC_WINDOW_DEPTH
) (
  input  logic    clk,
  input  logic    rst_n,
  owpc_in_if.sink   in_chan,
  owpc_out_if.source out_chan,
  owpc_cfg_if.sink  cfg_chan
);

  localparam int N     = WINDOW_DEPTH;
  localparam int CW    = $clog2(N + 1);
  localparam int PIPE  = 5;

  logic [15:0] rd_len_r;
  logic [15:0] seed_len_r;

  logic        advance;
  logic        accept;
  logic [32:0] need;

  owpc_entry_t     new_ent;
  owpc_entry_t     ent  [N];
  owpc_cell_stat_t stat [N];

  logic [N-1:0] intra_vec;
  logic [N-1:0] inter_vec;
  logic [N-1:0] a_intra_r;
  logic [N-1:0] a_inter_r;

  logic [PIPE-1:0] pipe_vld_r;
  logic [PIPE-1:0] pipe_start_r;
  logic [PIPE-1:0] pipe_ovf_r;

  logic [CW-1:0]    intra_cnt;
  logic [CW-1:0]    inter_cnt;
  logic [CW:0]      pair_cnt;

  logic [CNT_W-1:0] total_r;
  logic [CNT_W-1:0] intra_r;
  logic [CNT_W-1:0] inter_r;
  logic [CNT_W-1:0] total_base;
  logic [CNT_W-1:0] intra_base;
  logic [CNT_W-1:0] inter_base;
  logic             ovf_r;
  logic             out_valid_r;

  // configuration
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_len_r   <= RD_LEN_RST;
      seed_len_r <= SEED_LEN_RST;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.data.index)
        REG_RD_LEN:   rd_len_r   <= cfg_chan.data.data;
        REG_SEED_LEN: seed_len_r <= cfg_chan.data.data;
        default: ;
      endcase
    end
  end

  // handshake
  assign advance       = !out_valid_r || out_chan.ready;
  assign in_chan.ready = advance;
  assign accept        = in_chan.valid && advance;

  assign need = {1'b0, in_chan.data.map_position} + {17'b0, seed_len_r};

  assign new_ent.ref_name = in_chan.data.ref_name;
  assign new_ent.pos      = in_chan.data.map_position;
  assign new_ent.part     = in_chan.data.part_id;

  // cell row
  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_cell
      if (i == 0) begin : g_head
        owpc_cell u_cell (
          .clk        (clk),
          .rst_n      (rst_n),
          .shift_en   (accept),
          .start      (in_chan.data.start_of_set),
          .rec_ref    (in_chan.data.ref_name),
          .rec_part   (in_chan.data.part_id),
          .need       (need),
          .rd_len     (rd_len_r),
          .prev_ent   (new_ent),
          .prev_keep  (1'b1),
          .ent        (ent[i]),
          .stat       (stat[i])
        );
      end else begin : g_body
        owpc_cell u_cell (
          .clk        (clk),
          .rst_n      (rst_n),
          .shift_en   (accept),
          .start      (in_chan.data.start_of_set),
          .rec_ref    (in_chan.data.ref_name),
          .rec_part   (in_chan.data.part_id),
          .need       (need),
          .rd_len     (rd_len_r),
          .prev_ent   (ent[i-1]),
          .prev_keep  (stat[i-1].keep),
          .ent        (ent[i]),
          .stat       (stat[i])
        );
      end
      assign intra_vec[i] = stat[i].keep && stat[i].same_part;
      assign inter_vec[i] = stat[i].keep && !stat[i].same_part;
    end
  endgenerate

  // match vectors and sideband pipeline
  always_ff @(posedge clk) begin
    if (accept) begin
      a_intra_r <= intra_vec;
      a_inter_r <= inter_vec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_vld_r <= '0;
    end else if (advance) begin
      pipe_vld_r <= {pipe_vld_r[PIPE-2:0], in_chan.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pipe_start_r <= {pipe_start_r[PIPE-2:0], in_chan.data.start_of_set};
      pipe_ovf_r   <= {pipe_ovf_r[PIPE-2:0], stat[N-1].keep};
    end
  end

  owpc_popcnt #(.N(N)) u_intra_cnt (
    .clk (clk),
    .en  (advance),
    .bits(a_intra_r),
    .cnt (intra_cnt)
  );

  owpc_popcnt #(.N(N)) u_inter_cnt (
    .clk (clk),
    .en  (advance),
    .bits(a_inter_r),
    .cnt (inter_cnt)
  );

  // accumulation and result register
  assign pair_cnt   = {1'b0, intra_cnt} + {1'b0, inter_cnt};
  assign total_base = pipe_start_r[PIPE-1] ? '0 : total_r;
  assign intra_base = pipe_start_r[PIPE-1] ? '0 : intra_r;
  assign inter_base = pipe_start_r[PIPE-1] ? '0 : inter_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      intra_r     <= '0;
      inter_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= pipe_vld_r[PIPE-1];
      if (pipe_vld_r[PIPE-1]) begin
        total_r <= sat_add(total_base, CNT_W'(pair_cnt));
        intra_r <= sat_add(intra_base, CNT_W'(intra_cnt));
        inter_r <= sat_add(inter_base, CNT_W'(inter_cnt));
        ovf_r   <= (ovf_r && !pipe_start_r[PIPE-1]) || pipe_ovf_r[PIPE-1];
      end
    end
  end

  assign out_chan.valid                = out_valid_r;
  assign out_chan.data.total_pairs     = total_r;
  assign out_chan.data.intra_pairs     = intra_r;
  assign out_chan.data.inter_pairs     = inter_r;
  assign out_chan.data.window_overflow = ovf_r;

  // checks
  a_total_ge_intra: assert property (@(posedge clk) disable iff (!rst_n)
    total_r >= intra_r)
    else $error("total count below intra count");

  a_total_ge_inter: assert property (@(posedge clk) disable iff (!rst_n)
    total_r >= inter_r)
    else $error("total count below inter count");

  a_head_filled: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> stat[0].vld)
    else $error("head cell empty after accepted request");

  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && pipe_vld_r[PIPE-1] && !pipe_start_r[PIPE-1])
      |=> total_r >= $past(total_r))
    else $error("total count decreased without start of set");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && pipe_vld_r[PIPE-1] && pipe_ovf_r[PIPE-1]) |=> ovf_r)
    else $error("overflow not flagged");

endmodule
